>>> rtl/assert_macros.svh
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TRM_ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) else $error(msg);

// next-cycle implication
`define TRM_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) else $error(msg);

`endif

>>> rtl/trm_pkg.sv
`timescale 1ns / 1ps
package trm_pkg;

  localparam int STAT_COUNT       = 3;
  localparam int MISSED_TICK_BITS = 20;

  localparam int TIME_W   = 48;
  localparam int DELTA_W  = 32;
  localparam int RATE_W   = 56;
  localparam int TOTAL_W  = 48;
  localparam int TICK_W   = 32;
  localparam int DECAY_W  = 16;
  localparam int Q_W      = 17;
  localparam int FRAC_W   = 16;
  localparam int MUL_X_W  = RATE_W - FRAC_W;
  localparam int PROD_W   = MUL_X_W + Q_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int LO_W     = 2 * FRAC_W + 2;

  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;

  // divider: 64 by 32, two quotient bits a cycle
  localparam int DIV_W      = 64;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [TICK_W-1:0]  TICK_RESET  = 32'd1000;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TICK_LENGTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_DECAY_FACTOR = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_POW,
    ST_LANE,
    ST_DONE
  } trm_state_t;

  typedef enum logic [2:0] {
    LS_BLEND_HI,
    LS_BLEND_HI_R,
    LS_BLEND_LO,
    LS_BLEND_LO_R,
    LS_BLEND_WR,
    LS_DECAY_HI,
    LS_DECAY_LO,
    LS_DECAY_WR
  } lane_step_t;

  typedef struct packed {
    logic       start;
    logic       run;
    lane_step_t step;
    logic       n_pos;
    logic       n_gt1;
  } lane_ctl_t;

  function automatic logic [TOTAL_W-1:0] sat_add48(input logic [TOTAL_W-1:0] x,
                                                  input logic [DELTA_W-1:0] d);
    logic [TOTAL_W:0] s;
    s = {1'b0, x} + (TOTAL_W+1)'(d);
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

>>> rtl/trm_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trm_div import trm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [TICK_W-1:0]   divisor,
  output logic                done,
  output logic [DIV_W-1:0]    quotient,
  output logic [TICK_W-1:0]   remainder
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [TICK_W-1:0]    rem_r, rem_nxt;
  logic [TICK_W-1:0]    dvs_r;

  // restoring steps, dividend bits shift out of the top as quotient bits enter
  always_comb begin
    logic [TICK_W:0] trial;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial   = {rem_nxt, quo_nxt[DIV_W-1]};
      quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt    = TICK_W'(trial - {1'b0, dvs_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_CYCLES - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  `TRM_ASSERT_IMPL(a_div_rem_below_divisor, done_r, rem_r < dvs_r, "remainder not below divisor")

endmodule

>>> rtl/trm_pow.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trm_pow import trm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DECAY_W-1:0]          base,
  input  logic [MISSED_TICK_BITS-1:0] expo,
  output logic                        busy,
  output logic                        done,
  output logic [Q_W-1:0]              power
);

  logic                        busy_r;
  logic                        done_r;
  logic [Q_W-1:0]              p_r;
  logic [DECAY_W-1:0]          b_r;
  logic [MISSED_TICK_BITS-1:0] e_r;
  logic [Q_W+DECAY_W-1:0]      pb;
  logic [2*DECAY_W-1:0]        bb;

  assign pb = (Q_W+DECAY_W)'(p_r) * (Q_W+DECAY_W)'(b_r);
  assign bb = (2*DECAY_W)'(b_r) * (2*DECAY_W)'(b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && e_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // square and multiply from the low exponent bit up
  always_ff @(posedge clk) begin
    if (start) begin
      p_r <= Q_ONE;
      b_r <= base;
      e_r <= expo;
    end else if (busy_r && e_r != '0) begin
      if (e_r[0]) begin
        p_r <= pb[Q_W+FRAC_W-1:FRAC_W];
      end
      b_r <= bb[2*DECAY_W-1:FRAC_W];
      e_r <= e_r >> 1;
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign power = p_r;

  `TRM_ASSERT_IMPL(a_pow_at_most_one, busy_r, p_r <= Q_ONE, "power factor above one")

endmodule

>>> rtl/trm_lane.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trm_lane import trm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_ctl_t          ctl,
  input  logic [DELTA_W-1:0] delta,
  input  logic [TICK_W-1:0]  tick,
  input  logic [DECAY_W-1:0] decay,
  input  logic [Q_W-1:0]     power,
  output logic [RATE_W-1:0]  rate,
  output logic [TOTAL_W-1:0] total
);

  logic [TOTAL_W-1:0] pending_r;
  logic [RATE_W-1:0]  rate_r;
  logic [TOTAL_W-1:0] total_r;
  logic [DELTA_W-1:0] delta_r;
  logic [ACC_W-1:0]   acc_r;
  logic [LO_W-1:0]    lo_r;

  logic               div_done;
  logic [DIV_W-1:0]   quo;
  logic [TICK_W-1:0]  div_rem;
  logic [RATE_W-1:0]  raw;
  logic [Q_W-1:0]     a_q, b_q;
  logic [MUL_X_W-1:0] mul_x;
  logic [Q_W-1:0]     mul_f;
  logic [PROD_W-1:0]  prod;
  logic [RATE_W-1:0]  mix;

  trm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.start),
    .dividend ({pending_r, {FRAC_W{1'b0}}}),
    .divisor  (tick),
    .done     (div_done),
    .quotient (quo),
    .remainder(div_rem)
  );

  // raw rate saturates at the top of the rate range
  assign raw = (quo[DIV_W-1:RATE_W] != '0) ? {RATE_W{1'b1}} : quo[RATE_W-1:0];
  assign a_q = {1'b0, decay};
  assign b_q = Q_ONE - a_q;

  always_comb begin
    mul_x = '0;
    mul_f = '0;
    case (ctl.step)
      LS_BLEND_HI: begin
        mul_x = rate_r[RATE_W-1:FRAC_W];
        mul_f = a_q;
      end
      LS_BLEND_HI_R: begin
        mul_x = raw[RATE_W-1:FRAC_W];
        mul_f = b_q;
      end
      LS_BLEND_LO: begin
        mul_x = MUL_X_W'(rate_r[FRAC_W-1:0]);
        mul_f = a_q;
      end
      LS_BLEND_LO_R: begin
        mul_x = MUL_X_W'(raw[FRAC_W-1:0]);
        mul_f = b_q;
      end
      LS_DECAY_HI: begin
        mul_x = rate_r[RATE_W-1:FRAC_W];
        mul_f = power;
      end
      LS_DECAY_LO: begin
        mul_x = MUL_X_W'(rate_r[FRAC_W-1:0]);
        mul_f = power;
      end
      default: begin
        mul_x = '0;
        mul_f = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_x) * PROD_W'(mul_f);
  assign mix  = acc_r[RATE_W-1:0] + RATE_W'(lo_r[LO_W-1:FRAC_W]);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      delta_r <= delta;
    end
    if (ctl.run) begin
      case (ctl.step)
        LS_BLEND_HI:   acc_r <= ACC_W'(prod);
        LS_BLEND_HI_R: acc_r <= acc_r + ACC_W'(prod);
        LS_BLEND_LO:   lo_r  <= prod[LO_W-1:0];
        LS_BLEND_LO_R: lo_r  <= lo_r + prod[LO_W-1:0];
        LS_DECAY_HI:   acc_r <= ACC_W'(prod);
        LS_DECAY_LO:   lo_r  <= prod[LO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      rate_r    <= '0;
      total_r   <= '0;
    end else if (ctl.run) begin
      case (ctl.step)
        LS_BLEND_WR: begin
          if (ctl.n_pos) begin
            rate_r <= (rate_r == '0) ? raw : mix;
          end
        end
        LS_DECAY_WR: begin
          if (ctl.n_gt1) begin
            rate_r <= mix;
          end
          pending_r <= sat_add48(ctl.n_pos ? '0 : pending_r, delta_r);
          total_r   <= sat_add48(total_r, delta_r);
        end
        default: begin
        end
      endcase
    end
  end

  assign rate  = rate_r;
  assign total = total_r;

  `TRM_ASSERT_IMPL(a_lane_rem_below_tick, div_done, div_rem < tick, "lane remainder not below tick")

endmodule

>>> rtl/tick_quantized_ewma_rate_meter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Tick-quantized EWMA rate meter for three statistics.
// Input channel (in_valid/in_ready): a timestamp and three deltas per beat.
// Result channel (out_valid/out_ready): three Q40.16 rates and three
// saturating totals, one beat per input beat, in order.
// Config: APB-style port, tick_length at 0x0, decay_factor at 0x4; write
// only while the meter is idle. pready is tied high, reads are immediate.
// Each item runs one at a time: the elapsed-tick division and the three
// per-stat raw-rate divisions run side by side, then the missed-tick
// power, then the lanes' blend and decay steps, and last the load of the
// result register. A new item is accepted while the previous result still
// waits; if the receiver stalls longer, the finished item holds in the
// done state and in_ready stays low until the result register frees up.
// Synchronous reset clears all counts, rates, totals and the tick origin,
// and restores tick_length=1000 and decay_factor=58982.
module tick_quantized_ewma_rate_meter import trm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_W-1:0]     in_now_time,
  input  logic [DELTA_W-1:0]    in_delta_first,
  input  logic [DELTA_W-1:0]    in_delta_second,
  input  logic [DELTA_W-1:0]    in_delta_third,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RATE_W-1:0]     out_rate_first,
  output logic [RATE_W-1:0]     out_rate_second,
  output logic [RATE_W-1:0]     out_rate_third,
  output logic [TOTAL_W-1:0]    out_total_first,
  output logic [TOTAL_W-1:0]    out_total_second,
  output logic [TOTAL_W-1:0]    out_total_third,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  trm_state_t state_r, state_nxt;
  lane_step_t step_r;

  logic [TICK_W-1:0]  tick_length_r;
  logic [DECAY_W-1:0] decay_r;
  logic               started_r;
  logic [TIME_W-1:0]  origin_r;
  logic [TIME_W-1:0]  now_r;
  logic               lag_r;
  logic               n_pos_r;
  logic               n_gt1_r;
  logic               out_valid_r;
  logic [RATE_W-1:0]  out_rate_r  [STAT_COUNT];
  logic [TOTAL_W-1:0] out_total_r [STAT_COUNT];

  logic               accept;
  logic               lane_run;
  logic               pow_start;
  logic               out_load;
  logic               cfg_wr;

  logic [TICK_W-1:0]  tick_eff;
  logic [TIME_W-1:0]  origin_eff;
  logic               lag;
  logic [TIME_W-1:0]  diff;

  logic               tdiv_done;
  logic [DIV_W-1:0]   tdiv_quo;
  logic [TICK_W-1:0]  tdiv_rem;
  logic [TIME_W-1:0]  n_ticks;
  logic               n_pos, n_gt1;
  logic [MISSED_TICK_BITS-1:0] expo;

  logic               pow_busy, pow_done;
  logic [Q_W-1:0]     power;

  lane_ctl_t          lane_ctl;
  logic [DELTA_W-1:0] delta_arr [STAT_COUNT];
  logic [RATE_W-1:0]  lane_rate [STAT_COUNT];
  logic [TOTAL_W-1:0] lane_total[STAT_COUNT];

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr)
      ADDR_TICK_LENGTH:  cfg_prdata = tick_length_r;
      ADDR_DECAY_FACTOR: cfg_prdata = CFG_DATA_W'(decay_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_length_r <= TICK_RESET;
      decay_r       <= DECAY_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[REG_SEL_BIT]) begin
        decay_r <= cfg_pwdata[DECAY_W-1:0];
      end else begin
        tick_length_r <= cfg_pwdata[TICK_W-1:0];
      end
    end
  end

  // elapsed ticks since the origin
  assign tick_eff   = (tick_length_r == '0) ? TICK_W'(1) : tick_length_r;
  assign origin_eff = started_r ? origin_r : in_now_time;
  assign lag        = in_now_time < origin_eff;
  assign diff       = in_now_time - origin_eff;

  trm_div u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (DIV_W'(diff)),
    .divisor  (tick_eff),
    .done     (tdiv_done),
    .quotient (tdiv_quo),
    .remainder(tdiv_rem)
  );

  assign n_ticks = lag_r ? '0 : tdiv_quo[TIME_W-1:0];
  assign n_pos   = n_ticks != '0;
  assign n_gt1   = n_ticks > TIME_W'(1);

  // missed-tick exponent, count capped at 2^MISSED_TICK_BITS
  always_comb begin
    if (!n_gt1) begin
      expo = '0;
    end else if (n_ticks[TIME_W-1:MISSED_TICK_BITS] != '0) begin
      expo = '1;
    end else begin
      expo = n_ticks[MISSED_TICK_BITS-1:0] - 1'b1;
    end
  end

  trm_pow u_pow (
    .clk  (clk),
    .rst_n(rst_n),
    .start(pow_start),
    .base (decay_r),
    .expo (expo),
    .busy (pow_busy),
    .done (pow_done),
    .power(power)
  );

  // lanes
  assign delta_arr[0] = in_delta_first;
  assign delta_arr[1] = in_delta_second;
  assign delta_arr[2] = in_delta_third;

  assign lane_ctl.start = accept;
  assign lane_ctl.run   = lane_run;
  assign lane_ctl.step  = step_r;
  assign lane_ctl.n_pos = n_pos_r;
  assign lane_ctl.n_gt1 = n_gt1_r;

  for (genvar g = 0; g < STAT_COUNT; g++) begin : g_lane
    trm_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (lane_ctl),
      .delta(delta_arr[g]),
      .tick (tick_eff),
      .decay(decay_r),
      .power(power),
      .rate (lane_rate[g]),
      .total(lane_total[g])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV:  if (tdiv_done) state_nxt = ST_POW;
      ST_POW:  if (pow_done) state_nxt = ST_LANE;
      ST_LANE: if (step_r == LS_DECAY_WR) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    pow_start = 1'b0;
    lane_run  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_DIV:  pow_start = tdiv_done;
      ST_LANE: lane_run  = 1'b1;
      ST_DONE: out_load  = !out_valid_r || out_ready;
      default: in_ready  = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= LS_BLEND_HI;
      started_r   <= 1'b0;
      origin_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        started_r <= 1'b1;
        origin_r  <= origin_eff;
      end
      if (state_r == ST_DIV && tdiv_done && !lag_r) begin
        origin_r <= now_r - TIME_W'(tdiv_rem);
      end
      if (pow_done) begin
        step_r <= LS_BLEND_HI;
      end else if (lane_run) begin
        step_r <= lane_step_t'(step_r + 1'b1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_now_time;
      lag_r <= lag;
    end
    if (state_r == ST_DIV && tdiv_done) begin
      n_pos_r <= n_pos;
      n_gt1_r <= n_gt1;
    end
    if (out_load) begin
      for (int i = 0; i < STAT_COUNT; i++) begin
        out_rate_r[i]  <= lane_rate[i];
        out_total_r[i] <= lane_total[i];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rate_first   = out_rate_r[0];
  assign out_rate_second  = out_rate_r[1];
  assign out_rate_third   = out_rate_r[2];
  assign out_total_first  = out_total_r[0];
  assign out_total_second = out_total_r[1];
  assign out_total_third  = out_total_r[2];

  `TRM_ASSERT_IMPL(a_lane_after_pow, state_r == ST_LANE, !pow_busy, "lanes run while power busy")
  `TRM_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_r && state_r == ST_IDLE, "result not posted")

endmodule

>>> tb/tick_quantized_ewma_rate_meter_check.sv
`timescale 1ns / 1ps
module tick_quantized_ewma_rate_meter_check import trm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [TIME_W-1:0]     in_now_time,
  input  logic [DELTA_W-1:0]    in_delta_first,
  input  logic [DELTA_W-1:0]    in_delta_second,
  input  logic [DELTA_W-1:0]    in_delta_third,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [RATE_W-1:0]     out_rate_first,
  input  logic [RATE_W-1:0]     out_rate_second,
  input  logic [RATE_W-1:0]     out_rate_third,
  input  logic [TOTAL_W-1:0]    out_total_first,
  input  logic [TOTAL_W-1:0]    out_total_second,
  input  logic [TOTAL_W-1:0]    out_total_third,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    readings_owed
);

  typedef struct packed {
    logic [STAT_COUNT-1:0][RATE_W-1:0]  rate;
    logic [STAT_COUNT-1:0][TOTAL_W-1:0] total;
  } meter_reading_t;

  localparam logic [127:0] RATE_MAX  = (128'd1 << RATE_W) - 1;
  localparam logic [127:0] TOTAL_MAX = (128'd1 << TOTAL_W) - 1;

  meter_reading_t expected_readings[$];

  logic [TICK_W-1:0]  tick_len;
  logic [DECAY_W-1:0] decay;
  logic               seen_first;
  logic [TIME_W-1:0]  origin;
  logic [127:0]       pend[STAT_COUNT];
  logic [127:0]       smooth[STAT_COUNT];
  logic [127:0]       sum[STAT_COUNT];
  int                 printed;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    fail_count++;
    if (printed < 30) begin
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      printed++;
    end
  endtask

  task automatic advance_meter(input logic [TIME_W-1:0] now,
                               input logic [DELTA_W-1:0] d0, d1, d2);
    logic [127:0]   tick, n, ns, e, p, b, r, a;
    logic [DELTA_W-1:0] d[STAT_COUNT];
    meter_reading_t res;
    d[0] = d0; d[1] = d1; d[2] = d2;
    tick = (tick_len == 0) ? 128'd1 : 128'(tick_len);
    a = 128'(decay);
    n = 0;
    p = 128'd65536;
    if (!seen_first) begin
      origin = now;
      seen_first = 1'b1;
    end
    if (now >= origin) begin
      n = 128'(now - origin) / tick;
      origin = TIME_W'(128'(origin) + n * tick);
    end
    if (n > 1) begin
      ns = (n > (128'd1 << MISSED_TICK_BITS)) ? (128'd1 << MISSED_TICK_BITS) : n;
      e = ns - 1;
      b = a;
      while (e != 0) begin
        if (e[0]) p = (p * b) >> 16;
        b = (b * b) >> 16;
        e = e >> 1;
      end
    end
    for (int i = 0; i < STAT_COUNT; i++) begin
      if (n > 0) begin
        r = (pend[i] << 16) / tick;
        if (r > RATE_MAX) r = RATE_MAX;
        pend[i] = 0;
        if (smooth[i] == 0) smooth[i] = r;
        else smooth[i] = ((a * smooth[i] + (128'd65536 - a) * r) >> 16) & RATE_MAX;
      end
      if (n > 1) smooth[i] = ((smooth[i] * p) >> 16) & RATE_MAX;
      sum[i] = sum[i] + d[i];
      if (sum[i] > TOTAL_MAX) sum[i] = TOTAL_MAX;
      pend[i] = pend[i] + d[i];
      if (pend[i] > TOTAL_MAX) pend[i] = TOTAL_MAX;
      res.rate[i] = smooth[i][RATE_W-1:0];
      res.total[i] = sum[i][TOTAL_W-1:0];
    end
    expected_readings.push_back(res);
  endtask

  initial begin
    fail_count = 0;
    readings_owed = 0;
    printed = 0;
  end

  always @(posedge clk) begin
    meter_reading_t want;
    logic [STAT_COUNT-1:0][RATE_W-1:0]  got_rate;
    logic [STAT_COUNT-1:0][TOTAL_W-1:0] got_total;
    if (!rst_n) begin
      tick_len = TICK_RESET;
      decay = DECAY_RESET;
      seen_first = 1'b0;
      origin = '0;
      for (int i = 0; i < STAT_COUNT; i++) begin
        pend[i] = 0; smooth[i] = 0; sum[i] = 0;
      end
      expected_readings.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == ADDR_TICK_LENGTH) tick_len = cfg_pwdata[TICK_W-1:0];
        else if (cfg_paddr == ADDR_DECAY_FACTOR) decay = cfg_pwdata[DECAY_W-1:0];
      end
      if (in_valid && in_ready)
        advance_meter(in_now_time, in_delta_first, in_delta_second, in_delta_third);
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          report("unexpected beat", '0, '0);
        end else begin
          want = expected_readings.pop_front();
          got_rate = {out_rate_third, out_rate_second, out_rate_first};
          got_total = {out_total_third, out_total_second, out_total_first};
          for (int i = 0; i < STAT_COUNT; i++) begin
            if (got_rate[i] !== want.rate[i])
              report($sformatf("rate[%0d]", i), 64'(got_rate[i]), 64'(want.rate[i]));
            if (got_total[i] !== want.total[i])
              report($sformatf("total[%0d]", i), 64'(got_total[i]), 64'(want.total[i]));
          end
        end
      end
    end
    readings_owed <= expected_readings.size();
  end

endmodule

>>> tb/tick_quantized_ewma_rate_meter_test.sv
`timescale 1ns / 1ps
module tick_quantized_ewma_rate_meter_test;
  import trm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TIME_W-1:0]     in_now_time = '0;
  logic [DELTA_W-1:0]    in_delta_first = '0;
  logic [DELTA_W-1:0]    in_delta_second = '0;
  logic [DELTA_W-1:0]    in_delta_third = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RATE_W-1:0]     out_rate_first, out_rate_second, out_rate_third;
  logic [TOTAL_W-1:0]    out_total_first, out_total_second, out_total_third;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    fail_count;
  int                    readings_owed;

  int                    beats_sent = 0;
  logic                  burst_mode = 1'b0;
  logic                  hold_done = 1'b0;
  logic [TIME_W-1:0]     clock_now = '0;
  logic [63:0]           cur_tick = 64'd1000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tick_quantized_ewma_rate_meter dut (.*);

  tick_quantized_ewma_rate_meter_check check (
    .clk, .rst_n, .in_valid, .in_ready, .in_now_time, .in_delta_first,
    .in_delta_second, .in_delta_third, .out_valid, .out_ready, .out_rate_first,
    .out_rate_second, .out_rate_third, .out_total_first, .out_total_second,
    .out_total_third, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_pready, .fail_count, .readings_owed
  );

  task automatic send_beat(input logic [TIME_W-1:0] t, input logic [DELTA_W-1:0] a, b, c);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_now_time <= t;
    in_delta_first <= a;
    in_delta_second <= b;
    in_delta_third <= c;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [31:0] tick, input logic [15:0] dec);
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_owed != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    write_reg(ADDR_TICK_LENGTH, tick);
    write_reg(ADDR_DECAY_FACTOR, 32'(dec));
    cur_tick = (tick == 0) ? 64'd1 : 64'(tick);
  endtask

  function automatic logic [DELTA_W-1:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return DELTA_W'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [63:0] step;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
      case ($urandom_range(0, 19))
        0, 1: step = 0;
        2: step = {$urandom, $urandom};                      // large jump, may wrap back
        3: step = cur_tick * 64'($urandom_range(1, 3000000));
        default: step = (cur_tick * 64'($urandom_range(0, 3000))) / 1000;
      endcase
      clock_now = clock_now + TIME_W'(step);
      send_beat(clock_now, pick_delta(), pick_delta(), pick_delta());
    end
    burst_mode = 1'b0;
  endtask

  // receiver: random stalls plus one long hold-off while the sender keeps going
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && beats_sent > 300) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      stall = burst_mode ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #10ms;
    $display("tick_quantized_ewma_rate_meter regression: fail");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: start at time zero, whole ticks, missed ticks, time going back
    send_beat(48'd0, '1, '1, '1);
    send_beat(48'd0, '0, '0, '0);
    send_beat(48'd999, 32'd5, 32'd0, '1);
    send_beat(48'd1000, 32'd7, 32'd1, 32'd3);
    send_beat(48'd2000, 32'd100, 32'd200, 32'd300);
    send_beat(48'd6500, '1, 32'd0, 32'd9);
    send_beat(48'd100, 32'd1, 32'd2, 32'd3);
    send_beat(48'd7000, 32'd0, 32'd0, 32'd0);
    send_beat(48'd7000 + 48'd1000 * 48'd2000000, 32'd4, 32'd4, 32'd4);
    send_beat('1, '1, '1, '1);
    send_beat('1, 32'h5555_5555, 32'haaaa_aaaa, 32'd1);

    reconfigure(32'd0, 16'd0);
    clock_now = 48'h0000_0000_1000;
    send_beat(clock_now, 32'd3, 32'd3, 32'd3);
    send_beat(clock_now + 1, 32'd5, 32'd6, 32'd7);
    send_beat(clock_now + 5, '1, '1, '1);
    send_beat(clock_now + 6, 32'd1, 32'd1, 32'd1);
    send_beat(clock_now + 48'd3000000, 32'd2, 32'd2, 32'd2);
    clock_now = clock_now + 48'd3000000;

    reconfigure(32'hffff_ffff, 16'hffff);
    random_phase(200);
    reconfigure(32'd1, 16'hffff);
    random_phase(200);
    reconfigure(32'd0, 16'd0);
    random_phase(180);
    reconfigure(32'($urandom_range(2, 64)), 16'($urandom));
    random_phase(220);
    reconfigure(32'd7, 16'd32768);
    random_phase(200);
    reconfigure($urandom, 16'($urandom));
    random_phase(200);
    reconfigure(32'd1000, 16'd58982);
    random_phase(220);

    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_owed != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("tick_quantized_ewma_rate_meter regression: pass");
    end else begin
      $display("tick_quantized_ewma_rate_meter regression: fail");
    end
    $finish;
  end

endmodule
